// ===== src/knap_pkg.sv =====
// ----------------------------------------------------------------------------
// knap_pkg
// Shared constants, types and helpers of the 0/1 knapsack traceback unit.
// ----------------------------------------------------------------------------
package knap_pkg;

  localparam int MAX_ITEMS = 32;
  localparam int MAX_TIME  = 4095;

  localparam int CFG_W      = 12;
  localparam int DEPTH_W    = 11;
  localparam int GOLD_W     = 16;
  localparam int SUM_W      = 21;
  localparam int CNT_W      = $clog2(MAX_ITEMS + 1);
  localparam int IDX_W      = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
  localparam int TIME_W     = $clog2(MAX_TIME + 1);
  localparam int ROW_DEPTH  = MAX_TIME + 1;
  localparam int COST_W     = ((DEPTH_W + 2) > TIME_W) ? (DEPTH_W + 2) : TIME_W;
  localparam int TAKEN_AW   = IDX_W + TIME_W;
  localparam int TAKEN_DEPTH = MAX_ITEMS * ROW_DEPTH;

  localparam logic KIND_HEAD = 1'b0;
  localparam logic KIND_OBJ  = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SWEEP,
    ST_SWEEP_END,
    ST_TB_START,
    ST_TB_HEAD,
    ST_TB_ISSUE,
    ST_TB_WAIT,
    ST_EMIT_HEAD,
    ST_EMIT_OBJ
  } state_t;

  typedef struct packed {
    logic              we;
    logic [TIME_W-1:0] waddr;
    logic [SUM_W-1:0]  wdata;
    logic [TIME_W-1:0] raddr_a;
    logic [TIME_W-1:0] raddr_b;
  } row_req_t;

  typedef struct packed {
    logic                we;
    logic [TAKEN_AW-1:0] waddr;
    logic                wdata;
    logic [TAKEN_AW-1:0] raddr;
  } taken_req_t;

  // time cost of an object: three times its depth
  function automatic logic [COST_W-1:0] cost_of(input logic [DEPTH_W-1:0] depth);
    logic [COST_W-1:0] d;
    d = COST_W'(depth);
    return d + (d << 1);
  endfunction

endpackage

// ===== src/knap_if.sv =====
// ----------------------------------------------------------------------------
// knap_in_if / knap_out_if
// Valid/ready channels for object items and result items.
// ----------------------------------------------------------------------------
interface knap_in_if import knap_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [DEPTH_W-1:0] item_depth;
  logic [GOLD_W-1:0]  item_gold;
  logic               last;

  modport source (output valid, item_depth, item_gold, last, input ready);
  modport sink   (input valid, item_depth, item_gold, last, output ready);
endinterface

interface knap_out_if import knap_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               kind;
  logic [SUM_W-1:0]   best_gold;
  logic [CNT_W-1:0]   chosen_count;
  logic               overflow;
  logic [DEPTH_W-1:0] out_depth;
  logic [GOLD_W-1:0]  out_gold;
  logic               last_result;

  modport source (output valid, kind, best_gold, chosen_count, overflow, out_depth,
                  out_gold, last_result, input ready);
  modport sink   (input valid, kind, best_gold, chosen_count, overflow, out_depth,
                  out_gold, last_result, output ready);
endinterface

// ===== src/knapsack_01_with_traceback_unit.sv =====
// ----------------------------------------------------------------------------
// knapsack_01_with_traceback_unit
// 0/1 knapsack over a stream of objects with traceback of the chosen set.
// ----------------------------------------------------------------------------
// item_in carries one object per item (depth, gold, last); cost is 3 * depth.
// cfg_we/cfg_wdata set the time budget; write it only while the block is idle.
// For each object the best-value row is swept from the top capacity down, one
// entry per cycle through a two-stage read/modify/write of the row memory,
// writing one taken bit per capacity. Objects past the 32nd of a case skip
// the sweep and only set the overflow flag. After the last object a traceback
// walks the stored objects from the last back, then result_out gives a header
// item and one item per chosen object in input order, the final one with
// last_result set; after the header the stored objects are visited one per
// cycle unless a stall holds a chosen one, so unchosen objects leave one-cycle
// gaps. A stalled receiver holds the output register and pauses the emission;
// the next object is accepted once emission is done, even if a result still
// waits. Reset clears the budget, counters and flags; no memory clearing pass
// is needed since the first object of each case rewrites the whole row.
// ----------------------------------------------------------------------------
module knapsack_01_with_traceback_unit import knap_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic [CFG_W-1:0] cfg_wdata,
  knap_in_if.sink          item_in,
  knap_out_if.source       result_out
);

  row_req_t         row_req;
  taken_req_t       taken_req;
  logic [SUM_W-1:0] row_rd_a;
  logic [SUM_W-1:0] row_rd_b;
  logic             taken_rd;

  knap_row_ram u_row (
    .clk     (clk),
    .req     (row_req),
    .rdata_a (row_rd_a),
    .rdata_b (row_rd_b)
  );

  knap_taken_ram u_taken (
    .clk   (clk),
    .req   (taken_req),
    .rdata (taken_rd)
  );

  knap_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .item_in    (item_in),
    .result_out (result_out),
    .row_req    (row_req),
    .row_rd_a   (row_rd_a),
    .row_rd_b   (row_rd_b),
    .taken_req  (taken_req),
    .taken_rd   (taken_rd)
  );

endmodule

// ===== src/knap_row_ram.sv =====
// ----------------------------------------------------------------------------
// knap_row_ram
// Best-value row: one write port, two registered read ports.
// ----------------------------------------------------------------------------
module knap_row_ram import knap_pkg::*; (
  input  logic             clk,
  input  row_req_t         req,
  output logic [SUM_W-1:0] rdata_a,
  output logic [SUM_W-1:0] rdata_b
);

  logic [SUM_W-1:0] mem [ROW_DEPTH];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    rdata_a <= mem[req.raddr_a];
    rdata_b <= mem[req.raddr_b];
  end

endmodule

// ===== src/knap_taken_ram.sv =====
// ----------------------------------------------------------------------------
// knap_taken_ram
// Taken-bit store, one bit per object and capacity, registered read.
// ----------------------------------------------------------------------------
module knap_taken_ram import knap_pkg::*; (
  input  logic       clk,
  input  taken_req_t req,
  output logic       rdata
);

  logic mem [TAKEN_DEPTH];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    rdata <= mem[req.raddr];
  end

endmodule

// ===== src/knap_ctrl.sv =====
// ----------------------------------------------------------------------------
// knap_ctrl
// Row sweep pipeline, traceback sequencer and result register.
// ----------------------------------------------------------------------------
module knap_ctrl import knap_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [CFG_W-1:0]  cfg_wdata,
  knap_in_if.sink           item_in,
  knap_out_if.source        result_out,
  output row_req_t          row_req,
  input  logic [SUM_W-1:0]  row_rd_a,
  input  logic [SUM_W-1:0]  row_rd_b,
  output taken_req_t        taken_req,
  input  logic              taken_rd
);

  state_t state, state_next;

  logic [CFG_W-1:0]   time_limit;
  logic [TIME_W-1:0]  cap;
  logic [TIME_W-1:0]  cap_now;
  logic [DEPTH_W-1:0] obj_depth;
  logic [GOLD_W-1:0]  obj_gold;
  logic               obj_last;
  logic               first;
  logic [CNT_W-1:0]   count;
  logic               ovf_seen;
  logic [DEPTH_W-1:0] store_depth [MAX_ITEMS];
  logic [GOLD_W-1:0]  store_gold  [MAX_ITEMS];

  logic [TIME_W-1:0]  j;
  logic [COST_W-1:0]  cost;
  logic               fit_now;
  logic               s2_valid;
  logic [TIME_W-1:0]  s2_j;
  logic               s2_fit;
  logic [SUM_W-1:0]   old_val;
  logic [SUM_W-1:0]   base_val;
  logic [SUM_W-1:0]   cand;
  logic               improve;

  logic [CNT_W-1:0]   x;
  logic [IDX_W-1:0]   tb_idx;
  logic [IDX_W-1:0]   x_dec;
  logic [TIME_W-1:0]  rest;
  logic [COST_W-1:0]  tb_cost;
  logic [CNT_W-1:0]   nchosen;
  logic [MAX_ITEMS-1:0] chosen;
  logic [SUM_W-1:0]   best_gold;
  logic [IDX_W-1:0]   i;
  logic [CNT_W-1:0]   emitted;
  logic               emit_last;

  logic               in_acc;
  logic               slot_free;
  logic               load_head;
  logic               load_obj;
  logic               case_done;

  assign cap_now = (32'(time_limit) > MAX_TIME) ? TIME_W'(MAX_TIME) : TIME_W'(time_limit);
  assign in_acc    = item_in.valid && item_in.ready;
  assign slot_free = !result_out.valid || result_out.ready;
  assign cost      = cost_of(obj_depth);
  assign fit_now   = (j != '0) && (j <= cap) && (COST_W'(j) >= cost);
  assign x_dec     = IDX_W'(x - CNT_W'(1));
  assign tb_cost   = cost_of(store_depth[tb_idx]);
  assign emit_last = (emitted + CNT_W'(1)) == nchosen;

  // second sweep stage: the first object of a case sees an all-zero row
  assign old_val  = first ? '0 : row_rd_a;
  assign base_val = first ? '0 : row_rd_b;
  assign cand     = base_val + SUM_W'(obj_gold);
  assign improve  = s2_fit && (cand > old_val);

  always_comb begin
    row_req.we      = s2_valid;
    row_req.waddr   = s2_j;
    row_req.wdata   = improve ? cand : old_val;
    row_req.raddr_a = (state == ST_TB_START) ? cap : j;
    row_req.raddr_b = j - TIME_W'(cost);
    taken_req.we    = s2_valid;
    taken_req.waddr = {count[IDX_W-1:0], s2_j};
    taken_req.wdata = improve;
    taken_req.raddr = {x_dec, rest};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next    = state;
    item_in.ready = 1'b0;
    load_head     = 1'b0;
    load_obj      = 1'b0;
    case_done     = 1'b0;
    unique case (state)
      ST_IDLE: begin
        item_in.ready = 1'b1;
        if (item_in.valid) begin
          if (count < CNT_W'(MAX_ITEMS)) begin
            state_next = ST_SWEEP;
          end else if (item_in.last) begin
            state_next = ST_TB_START;
          end
        end
      end
      ST_SWEEP: begin
        if (j == '0) begin
          state_next = ST_SWEEP_END;
        end
      end
      ST_SWEEP_END: begin
        state_next = obj_last ? ST_TB_START : ST_IDLE;
      end
      ST_TB_START: state_next = ST_TB_HEAD;
      ST_TB_HEAD:  state_next = ST_TB_ISSUE;
      ST_TB_ISSUE: begin
        state_next = (x == '0) ? ST_EMIT_HEAD : ST_TB_WAIT;
      end
      ST_TB_WAIT: state_next = ST_TB_ISSUE;
      ST_EMIT_HEAD: begin
        if (slot_free) begin
          load_head = 1'b1;
          if (nchosen == '0) begin
            case_done  = 1'b1;
            state_next = ST_IDLE;
          end else begin
            state_next = ST_EMIT_OBJ;
          end
        end
      end
      ST_EMIT_OBJ: begin
        if (chosen[i] && slot_free) begin
          load_obj = 1'b1;
          if (emit_last) begin
            case_done  = 1'b1;
            state_next = ST_IDLE;
          end
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      time_limit        <= '0;
      count             <= '0;
      ovf_seen          <= 1'b0;
      s2_valid          <= 1'b0;
      result_out.valid  <= 1'b0;
    end else begin
      if (cfg_we) begin
        time_limit <= cfg_wdata;
      end
      s2_valid <= (state == ST_SWEEP);
      if (state == ST_SWEEP_END) begin
        count <= count + CNT_W'(1);
      end
      if (in_acc && count >= CNT_W'(MAX_ITEMS)) begin
        ovf_seen <= 1'b1;
      end
      if (case_done) begin
        count    <= '0;
        ovf_seen <= 1'b0;
      end
      if (load_head || load_obj) begin
        result_out.valid <= 1'b1;
      end else if (result_out.ready) begin
        result_out.valid <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      obj_depth <= item_in.item_depth;
      obj_gold  <= item_in.item_gold;
      obj_last  <= item_in.last;
      cap       <= cap_now;
      first     <= (count == '0);
      j         <= TIME_W'(MAX_TIME);
      if (count < CNT_W'(MAX_ITEMS)) begin
        store_depth[count[IDX_W-1:0]] <= item_in.item_depth;
        store_gold[count[IDX_W-1:0]]  <= item_in.item_gold;
      end
    end
    if (state == ST_SWEEP) begin
      j <= j - TIME_W'(1);
    end
    s2_j   <= j;
    s2_fit <= fit_now;

    unique case (state)
      ST_TB_START: begin
        x       <= count;
        rest    <= cap;
        nchosen <= '0;
        chosen  <= '0;
      end
      ST_TB_HEAD: begin
        best_gold <= row_rd_a;
      end
      ST_TB_ISSUE: begin
        if (x != '0) begin
          x      <= x - CNT_W'(1);
          tb_idx <= x_dec;
        end
        i       <= '0;
        emitted <= '0;
      end
      ST_TB_WAIT: begin
        if (taken_rd) begin
          chosen[tb_idx] <= 1'b1;
          nchosen        <= nchosen + CNT_W'(1);
          rest <= (tb_cost <= COST_W'(rest)) ? TIME_W'(COST_W'(rest) - tb_cost) : '0;
        end
      end
      ST_EMIT_OBJ: begin
        if (!chosen[i] || slot_free) begin
          i <= i + IDX_W'(1);
        end
        if (load_obj) begin
          emitted <= emitted + CNT_W'(1);
        end
      end
      default: begin
      end
    endcase

    if (load_head) begin
      result_out.kind         <= KIND_HEAD;
      result_out.best_gold    <= best_gold;
      result_out.chosen_count <= nchosen;
      result_out.overflow     <= ovf_seen;
      result_out.out_depth    <= '0;
      result_out.out_gold     <= '0;
      result_out.last_result  <= (nchosen == '0);
    end else if (load_obj) begin
      result_out.kind         <= KIND_OBJ;
      result_out.best_gold    <= '0;
      result_out.chosen_count <= '0;
      result_out.overflow     <= 1'b0;
      result_out.out_depth    <= store_depth[i];
      result_out.out_gold     <= store_gold[i];
      result_out.last_result  <= emit_last;
    end
  end

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(MAX_ITEMS))
    else $error("object count above limit");

  a_row_no_raw: assert property (@(posedge clk) disable iff (rst)
    (row_req.we && state == ST_SWEEP) |-> (row_req.raddr_a != row_req.waddr))
    else $error("row read and write collide");

  a_rest_bound: assert property (@(posedge clk) disable iff (rst)
    (state == ST_TB_ISSUE || state == ST_TB_WAIT) |-> (rest <= cap))
    else $error("traceback capacity above budget");

  a_emit_bound: assert property (@(posedge clk) disable iff (rst)
    (state == ST_EMIT_OBJ) |-> (emitted < nchosen))
    else $error("more objects emitted than chosen");

  a_last_done: assert property (@(posedge clk) disable iff (rst)
    case_done |=> (count == '0 && !ovf_seen))
    else $error("case state not cleared");
`endif

endmodule
